// File: src/tfn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfn_pkg
// Shared constants and types for the triangle face normal core.
// ---------------------------------------------------------------------------
package tfn_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int FRAC_BITS           = 14;   // Q1.14 output
   localparam int QUOT_BITS           = 15;   // quotient bits, magnitude <= 2^14
   localparam int NORMAL_WIDTH        = 16;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_DIVIDE,
      ST_DONE
   } tfn_state_type;

   // part of a magnitude square being formed: hi*hi, hi*lo, lo*lo
   typedef enum logic [1:0] {
      PART_HH,
      PART_HL,
      PART_LL
   } tfn_part_type;

endpackage
`default_nettype wire

// File: src/triangle_face_normal_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle in signed Q1.14.
// ---------------------------------------------------------------------------
// Each req transfer carries three corners; each rsp transfer returns the unit
// normal of (second - first) x (third - first), components rounded to nearest
// (ties away from zero), plus a degenerate flag when the cross product is zero.
// Rate: the front takes one triangle per cycle while the queue has room, through
// three stages (edges, six products, cross) into a four-entry queue, so bursts
// are absorbed. The back normalizes one triangle at a time on a shared
// sequencer: it pops the queue, forms the sum of squares on one multiplier,
// takes a bit-serial root, divides in three parallel divide lanes and loads
// the output register. A degenerate triangle goes from the pop straight to
// the output load. The back takes no new triangle until the last one is in
// the output register. Through an empty block a triangle passes the three
// front stages, the queue and then the back sequence.
// ---------------------------------------------------------------------------
module triangle_face_normal_core #(
   parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]         req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_first_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_first_z,
   input  wire logic signed [COORD_WIDTH-1:0]         req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_second_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_second_z,
   input  wire logic signed [COORD_WIDTH-1:0]         req_third_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_third_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_third_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]    rsp_normal_x,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]    rsp_normal_y,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]    rsp_normal_z,
   output logic                                       rsp_degenerate
);
   import tfn_pkg::*;

   // queue entry: {zero flag, cz, cy, cx}, each cross term 2W+3 bits signed
   localparam int EW = 3 * (2 * COORD_WIDTH + 3) + 1;

   logic          push_valid, push_ready;
   logic [EW-1:0] push_data;
   logic          pop_valid, pop;
   logic [EW-1:0] pop_data;

   tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_first_z  (req_first_z),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .req_second_z (req_second_z),
      .req_third_x  (req_third_x),
      .req_third_y  (req_third_y),
      .req_third_z  (req_third_z),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   // decouples the front, one triangle per cycle while it can push, from the iterative back
   tfn_queue #(.DATA_WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   tfn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (pop_valid),
      .q_pop          (pop),
      .q_data         (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule
`default_nettype wire

// File: src/tfn_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfn_front
// Edge vectors, cross product and zero check, three register stages.
// ---------------------------------------------------------------------------
module tfn_front #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]     req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0]     req_first_y,
   input  wire logic signed [COORD_WIDTH-1:0]     req_first_z,
   input  wire logic signed [COORD_WIDTH-1:0]     req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0]     req_second_y,
   input  wire logic signed [COORD_WIDTH-1:0]     req_second_z,
   input  wire logic signed [COORD_WIDTH-1:0]     req_third_x,
   input  wire logic signed [COORD_WIDTH-1:0]     req_third_y,
   input  wire logic signed [COORD_WIDTH-1:0]     req_third_z,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output logic [3*(2*COORD_WIDTH+3):0]           push_data
);
   import tfn_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int CW = 2 * COORD_WIDTH + 3;

   logic advance;

   logic              s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [DW-1:0] px_ff, py_ff, pz_ff, qx_ff, qy_ff, qz_ff;
   logic signed [DW-1:0] px_in, py_in, pz_in, qx_in, qy_in, qz_in;
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [CW-1:0] cx_in, cy_in, cz_in;

   assign advance   = !s3_vld_ff || push_ready;
   assign req_ready = advance;

   always_comb begin
      px_in = DW'(req_second_x) - DW'(req_first_x);
      py_in = DW'(req_second_y) - DW'(req_first_y);
      pz_in = DW'(req_second_z) - DW'(req_first_z);
      qx_in = DW'(req_third_x) - DW'(req_first_x);
      qy_in = DW'(req_third_y) - DW'(req_first_y);
      qz_in = DW'(req_third_z) - DW'(req_first_z);
      cx_in = CW'(m0_ff) - CW'(m1_ff);
      cy_in = CW'(m2_ff) - CW'(m3_ff);
      cz_in = CW'(m4_ff) - CW'(m5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         m0_ff <= PW'(py_ff) * PW'(qz_ff);
         m1_ff <= PW'(pz_ff) * PW'(qy_ff);
         m2_ff <= PW'(pz_ff) * PW'(qx_ff);
         m3_ff <= PW'(px_ff) * PW'(qz_ff);
         m4_ff <= PW'(px_ff) * PW'(qy_ff);
         m5_ff <= PW'(py_ff) * PW'(qx_ff);
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
   end

   assign push_valid = s3_vld_ff;
   assign push_data  = {(cx_ff == '0) && (cy_ff == '0) && (cz_ff == '0), cz_ff, cy_ff, cx_ff};

endmodule
`default_nettype wire

// File: src/tfn_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfn_queue
// Small FIFO between the cross product front and the normalize back.
// ---------------------------------------------------------------------------
module tfn_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       pop_valid,
   input  wire logic                  pop,
   output logic [DATA_WIDTH-1:0]      pop_data
);
   import tfn_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]         wr_ff, rd_ff;
   logic [NW-1:0]         count_ff;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count lost on pop");

endmodule
`default_nettype wire

// File: src/tfn_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfn_back
// Normalize sequencer: sum of squares, bit serial root, three divide lanes.
// ---------------------------------------------------------------------------
module tfn_back #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  q_valid,
   output logic                                       q_pop,
   input  wire logic [3*(2*COORD_WIDTH+3):0]          q_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]    rsp_normal_x,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]    rsp_normal_y,
   output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]    rsp_normal_z,
   output logic                                       rsp_degenerate
);
   import tfn_pkg::*;

   localparam int CW   = 2 * COORD_WIDTH + 3;
   localparam int MW   = 2 * COORD_WIDTH + 2;
   localparam int HW   = COORD_WIDTH + 1;
   localparam int SW   = 2 * MW;
   localparam int RW   = MW;
   localparam int REMW = RW + 2;
   localparam int RCW  = $clog2(RW);
   localparam int QCW  = $clog2(QUOT_BITS);
   localparam int NW   = NORMAL_WIDTH;

   tfn_state_type state_ff, state_in;

   logic            load_out;
   logic [MW-1:0]   mag_ff [3];
   logic            neg_ff [3];
   logic            degen_ff;

   // square phase
   logic [1:0]      comp_ff;
   tfn_part_type    part_ff, prod_part_ff;
   logic            prod_vld_ff, issued_ff;
   logic [MW-1:0]   prod_ff;
   logic [MW-1:0]   sel_mag;
   logic [HW-1:0]   op_a, op_b;
   logic [SW-1:0]   sum_ff, acc_term;
   logic            square_done;

   // root phase
   logic [REMW-1:0] rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [REMW:0]   rem_t, trial;
   logic [RCW-1:0]  rcnt_ff;

   // divide phase
   logic [RW-1:0]        r_ff [3];
   logic [RW-1:0]        r_in [3];
   logic [QUOT_BITS-1:0] q_ff [3];
   logic [QUOT_BITS-1:0] q_in [3];
   logic [QCW-1:0]       dcnt_ff;
   logic [NW-1:0]        nrm   [3];

   logic                 rsp_valid_ff;
   logic signed [NW-1:0] nx_ff, ny_ff, nz_ff;
   logic                 dg_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = q_data[3*CW] ? ST_DONE : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (square_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rcnt_ff == '0) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (dcnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop       = (state_ff == ST_IDLE) && q_valid;
      load_out    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      square_done = (state_ff == ST_SQUARE) && issued_ff && prod_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      sel_mag = mag_ff[comp_ff];
      unique case (part_ff)
         PART_HH: begin
            op_a = sel_mag[MW-1:HW];
            op_b = sel_mag[MW-1:HW];
         end
         PART_HL: begin
            op_a = sel_mag[MW-1:HW];
            op_b = sel_mag[HW-1:0];
         end
         default: begin
            op_a = sel_mag[HW-1:0];
            op_b = sel_mag[HW-1:0];
         end
      endcase
      unique case (prod_part_ff)
         PART_HH: acc_term = SW'(prod_ff) << (2 * HW);
         PART_HL: acc_term = SW'(prod_ff) << (HW + 1);
         default: acc_term = SW'(prod_ff);
      endcase
   end

   // root recurrence, one result bit per cycle
   always_comb begin
      rem_t = {rem_ff[REMW-2:0], sum_ff[SW-1:SW-2]};
      trial = (REMW + 1)'({root_ff, 2'b01});
      if (rem_t >= trial) begin
         rem_in  = REMW'(rem_t - trial);
         root_in = {root_ff[RW-2:0], 1'b1};
      end else begin
         rem_in  = REMW'(rem_t);
         root_in = {root_ff[RW-2:0], 1'b0};
      end
   end

   // divide lanes and final rounding
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [RW:0]   t;
         logic          dbit;
         logic          ge;
         logic          rnd;
         logic [NW-1:0] qm;
         dbit = (dcnt_ff == QCW'(QUOT_BITS - 1)) ? mag_ff[i][0] : 1'b0;
         t    = {r_ff[i], dbit};
         ge   = (t >= {1'b0, root_ff});
         r_in[i] = ge ? RW'(t - {1'b0, root_ff}) : RW'(t);
         q_in[i] = {q_ff[i][QUOT_BITS-2:0], ge};
         rnd  = ({r_ff[i], 1'b0} >= {1'b0, root_ff});
         qm   = NW'(q_ff[i]) + NW'(rnd);
         nrm[i] = degen_ff ? '0 : (neg_ff[i] ? NW'(-qm) : qm);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         issued_ff   <= 1'b0;
         comp_ff     <= '0;
         part_ff     <= PART_HH;
      end else begin
         if (q_pop) begin
            prod_vld_ff <= 1'b0;
            issued_ff   <= 1'b0;
            comp_ff     <= '0;
            part_ff     <= PART_HH;
         end else if (state_ff == ST_SQUARE && !issued_ff) begin
            prod_vld_ff <= 1'b1;
            if (part_ff == PART_LL) begin
               part_ff <= PART_HH;
               if (comp_ff == 2'd2) begin
                  issued_ff <= 1'b1;
               end else begin
                  comp_ff <= comp_ff + 1'b1;
               end
            end else begin
               part_ff <= tfn_part_type'(part_ff + 1'b1);
            end
         end else begin
            prod_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [CW-1:0] c;
            c = q_data[i*CW +: CW];
            neg_ff[i] <= c[CW-1];
            mag_ff[i] <= c[CW-1] ? MW'(-c) : MW'(c);
         end
         degen_ff <= q_data[3*CW];
         sum_ff   <= '0;
      end
      if (state_ff == ST_SQUARE) begin
         prod_ff      <= op_a * op_b;
         prod_part_ff <= part_ff;
         if (prod_vld_ff) begin
            sum_ff <= sum_ff + acc_term;
         end
      end
      if (square_done) begin
         rem_ff  <= '0;
         root_ff <= '0;
         rcnt_ff <= RCW'(RW - 1);
      end
      if (state_ff == ST_ROOT) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sum_ff  <= sum_ff << 2;
         rcnt_ff <= rcnt_ff - 1'b1;
         if (rcnt_ff == '0) begin
            dcnt_ff <= QCW'(QUOT_BITS - 1);
            for (int i = 0; i < 3; i++) begin
               r_ff[i] <= RW'(mag_ff[i] >> 1);
               q_ff[i] <= '0;
            end
         end
      end
      if (state_ff == ST_DIVIDE) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         for (int i = 0; i < 3; i++) begin
            r_ff[i] <= r_in[i];
            q_ff[i] <= q_in[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         nx_ff <= nrm[0];
         ny_ff <= nrm[1];
         nz_ff <= nrm[2];
         dg_ff <= degen_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = nx_ff;
   assign rsp_normal_y   = ny_ff;
   assign rsp_normal_z   = nz_ff;
   assign rsp_degenerate = dg_ff;

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (root_ff != '0))
      else $error("divide started with zero length");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dg_ff) |-> (nx_ff == '0 && ny_ff == '0 && nz_ff == '0))
      else $error("degenerate result with nonzero normal");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while busy");

endmodule
`default_nettype wire
